// ----- src/tcw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, register indexes, controller states and the command and
// status bundles of the text console cell writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_LINES   = 64;

  localparam int COL_W      = $clog2(MAX_COLUMNS);
  localparam int ROW_W      = $clog2(MAX_LINES);
  localparam int CELL_AW    = ROW_W + COL_W;
  localparam int CELL_DEPTH = MAX_COLUMNS * MAX_LINES;
  localparam int CELL_W     = 16;
  localparam int ADDR_W     = 20;
  localparam int CHAR_W     = 8;
  localparam int COLS_W     = 8;
  localparam int LINES_W    = 7;
  localparam int LIN_W      = ROW_W + COLS_W;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  localparam logic [CELL_W-1:0] CELL_CHAR   = 16'h0200;
  localparam logic [CELL_W-1:0] CELL_CURSOR = 16'h02DB;
  localparam logic [CHAR_W-1:0] CODE_BS     = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_CR     = 8'h0D;

  localparam logic [COLS_W-1:0]  RST_COLUMNS      = 8'd80;
  localparam logic [LINES_W-1:0] RST_VISIBLE_ROWS = 7'd25;
  localparam logic [LINES_W-1:0] RST_RING_LINES   = 7'd64;

  typedef enum logic [1:0] {
    REG_COLUMNS,
    REG_VISIBLE_ROWS,
    REG_RING_LINES,
    REG_BASE_ADDRESS
  } reg_idx_t;

  typedef struct packed {
    logic [COLS_W-1:0]  columns;
    logic [LINES_W-1:0] visible_rows;
    logic [LINES_W-1:0] ring_lines;
    logic [ADDR_W-1:0]  base_address;
  } cfg_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CALC,
    S_FIRST,
    S_READ,
    S_PICK,
    S_MUL,
    S_CLEAR,
    S_SWEEP,
    S_CUR
  } state_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic write_first;
    logic read_prev;
    logic pick;
    logic mul;
    logic emit_clear;
    logic sweep;
    logic write_cursor;
    logic init_step;
  } cmd_t;

  typedef struct packed {
    logic is_bs;
    logic scroll;
    logic out_free;
    logic sweep_done;
    logic init_done;
  } status_t;

endpackage

// ----- src/tcw_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/tcw_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_regs
// APB configuration registers: columns, visible rows, ring lines, base address.
// ----------------------------------------------------------------------------
module tcw_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcw_pkg::PADDR_W-1:0] paddr,
  input  logic [tcw_pkg::PDATA_W-1:0] pwdata,
  output logic [tcw_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output tcw_pkg::cfg_t               cfg
);

  tcw_pkg::cfg_t    cfg_r;
  tcw_pkg::reg_idx_t idx;
  logic             wr;

  assign pready = 1'b1;
  assign idx    = tcw_pkg::reg_idx_t'(paddr[tcw_pkg::PADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_r.columns      <= tcw_pkg::RST_COLUMNS;
      cfg_r.visible_rows <= tcw_pkg::RST_VISIBLE_ROWS;
      cfg_r.ring_lines   <= tcw_pkg::RST_RING_LINES;
      cfg_r.base_address <= '0;
    end else if (wr) begin
      unique case (idx)
        tcw_pkg::REG_COLUMNS:      cfg_r.columns      <= pwdata[tcw_pkg::COLS_W-1:0];
        tcw_pkg::REG_VISIBLE_ROWS: cfg_r.visible_rows <= pwdata[tcw_pkg::LINES_W-1:0];
        tcw_pkg::REG_RING_LINES:   cfg_r.ring_lines   <= pwdata[tcw_pkg::LINES_W-1:0];
        tcw_pkg::REG_BASE_ADDRESS: cfg_r.base_address <= pwdata[tcw_pkg::ADDR_W-1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      tcw_pkg::REG_COLUMNS:
        prdata[tcw_pkg::COLS_W-1:0] = cfg_r.columns;
      tcw_pkg::REG_VISIBLE_ROWS:
        prdata[tcw_pkg::LINES_W-1:0] = cfg_r.visible_rows;
      tcw_pkg::REG_RING_LINES:
        prdata[tcw_pkg::LINES_W-1:0] = cfg_r.ring_lines;
      tcw_pkg::REG_BASE_ADDRESS:
        prdata[tcw_pkg::ADDR_W-1:0] = cfg_r.base_address;
    endcase
  end

endmodule

// ----- src/tcw_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_datapath
// Cursor and window state, position arithmetic, address generation, the cell
// mirror RAM and the output register.
// ----------------------------------------------------------------------------
module tcw_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  tcw_pkg::cfg_t              cfg,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code,
  input  tcw_pkg::cmd_t              cmd,
  output tcw_pkg::status_t           sts,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [tcw_pkg::ADDR_W-1:0] write_address,
  output logic [tcw_pkg::CELL_W-1:0] cell_value,
  output logic                       clear_line,
  output logic [tcw_pkg::ROW_W-1:0]  top_line,
  output logic                       last
);

  localparam int COL_W   = tcw_pkg::COL_W;
  localparam int ROW_W   = tcw_pkg::ROW_W;
  localparam int COLS_W  = tcw_pkg::COLS_W;
  localparam int LINES_W = tcw_pkg::LINES_W;
  localparam int LIN_W   = tcw_pkg::LIN_W;
  localparam int CELL_AW = tcw_pkg::CELL_AW;
  localparam int CELL_W  = tcw_pkg::CELL_W;
  localparam int ADDR_W  = tcw_pkg::ADDR_W;

  // architectural state
  logic [ROW_W-1:0] cursor_row;
  logic [COL_W-1:0] cursor_col;
  logic [ROW_W-1:0] window_top;

  // per-transaction registers
  logic [tcw_pkg::CHAR_W-1:0] code_r;
  logic [ROW_W-1:0]  cur_row, new_row, prev_row, wt, new_top;
  logic [COL_W-1:0]  cur_col, new_col, prev_col;
  logic [LIN_W-1:0]  prod;
  logic              scroll;
  logic [CELL_W-1:0] first_val;
  logic [CELL_AW-1:0] cnt;

  // effective configuration
  logic [COLS_W-1:0]  cols_eff, cols_m1;
  logic [LINES_W-1:0] lines_eff, lines_m1, rows_eff;

  always_comb begin
    if (cfg.columns == '0) begin
      cols_eff = COLS_W'(1);
    end else if (cfg.columns > COLS_W'(tcw_pkg::MAX_COLUMNS)) begin
      cols_eff = COLS_W'(tcw_pkg::MAX_COLUMNS);
    end else begin
      cols_eff = cfg.columns;
    end
    if (cfg.ring_lines == '0) begin
      lines_eff = LINES_W'(1);
    end else if (cfg.ring_lines > LINES_W'(tcw_pkg::MAX_LINES)) begin
      lines_eff = LINES_W'(tcw_pkg::MAX_LINES);
    end else begin
      lines_eff = cfg.ring_lines;
    end
    if (cfg.visible_rows == '0) begin
      rows_eff = LINES_W'(1);
    end else if (cfg.visible_rows > lines_eff) begin
      rows_eff = lines_eff;
    end else begin
      rows_eff = cfg.visible_rows;
    end
    cols_m1  = cols_eff - COLS_W'(1);
    lines_m1 = lines_eff - LINES_W'(1);
  end

  // position arithmetic for the step
  logic              is_bs, is_nl, col_wrap, moved, scroll_c;
  logic [ROW_W-1:0]  nxt_row, tgt_row, top_inc, prv_row_c;
  logic [COL_W-1:0]  tgt_col, prv_col_c;
  logic [LINES_W-1:0] row_gap;

  always_comb begin
    is_bs    = code_r == tcw_pkg::CODE_BS;
    is_nl    = code_r == tcw_pkg::CODE_LF || code_r == tcw_pkg::CODE_CR;
    nxt_row  = ({1'b0, cur_row} + LINES_W'(1) == lines_eff) ? '0 : cur_row + ROW_W'(1);
    top_inc  = ({1'b0, wt} + LINES_W'(1) == lines_eff) ? '0 : wt + ROW_W'(1);
    col_wrap = ({1'b0, cur_col} + COLS_W'(1)) >= cols_eff;
    if (is_nl) begin
      tgt_row = nxt_row;
      tgt_col = '0;
      moved   = 1'b1;
    end else if (col_wrap) begin
      tgt_row = nxt_row;
      tgt_col = '0;
      moved   = nxt_row != cur_row;
    end else begin
      tgt_row = cur_row;
      tgt_col = cur_col + COL_W'(1);
      moved   = 1'b0;
    end
    if (tgt_row > wt) begin
      row_gap = {1'b0, tgt_row} - {1'b0, wt};
    end else begin
      row_gap = lines_eff + {1'b0, tgt_row} - {1'b0, wt};
    end
    scroll_c = moved && !is_bs && (row_gap == rows_eff);
    if (cur_col != '0) begin
      prv_row_c = cur_row;
      prv_col_c = cur_col - COL_W'(1);
    end else if (cur_row != '0) begin
      prv_row_c = cur_row - ROW_W'(1);
      prv_col_c = cols_m1[COL_W-1:0];
    end else begin
      prv_row_c = lines_m1[ROW_W-1:0];
      prv_col_c = cols_m1[COL_W-1:0];
    end
  end

  // cell mirror
  logic               ram_we;
  logic [CELL_AW-1:0] ram_waddr;
  logic [CELL_W-1:0]  ram_wdata, ram_rdata;

  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = {cur_row, cur_col};
    ram_wdata = '0;
    priority if (cmd.init_step) begin
      ram_waddr = cnt;
    end else if (cmd.sweep) begin
      ram_waddr = {new_row, cnt[COL_W-1:0]};
    end else if (cmd.write_first) begin
      ram_wdata = first_val;
    end else if (cmd.write_cursor) begin
      ram_waddr = {new_row, new_col};
      ram_wdata = tcw_pkg::CELL_CURSOR;
    end else begin
      ram_we = 1'b0;
    end
  end

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(tcw_pkg::CELL_DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.read_prev),
    .raddr ({prev_row, prev_col}),
    .rdata (ram_rdata)
  );

  // address of a cell or line start
  logic [ADDR_W-1:0] addr_cur, addr_new, addr_line;

  assign addr_cur  = cfg.base_address
                   + {{(ADDR_W-LIN_W-1){1'b0}}, prod + LIN_W'(cur_col), 1'b0};
  assign addr_new  = cfg.base_address
                   + {{(ADDR_W-LIN_W-1){1'b0}}, prod + LIN_W'(new_col), 1'b0};
  assign addr_line = cfg.base_address + {{(ADDR_W-LIN_W-1){1'b0}}, prod, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row <= '0;
      cursor_col <= '0;
      window_top <= '0;
      cnt        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.init_step || cmd.sweep) begin
        cnt <= cnt + CELL_AW'(1);
      end else if (cmd.emit_clear) begin
        cnt <= '0;
      end
      if (cmd.write_cursor) begin
        cursor_row <= new_row;
        cursor_col <= new_col;
        window_top <= new_top;
      end
      if (cmd.write_first || cmd.emit_clear || cmd.write_cursor) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code_r  <= char_code;
      cur_row <= ({1'b0, cursor_row} >= lines_eff) ? '0 : cursor_row;
      cur_col <= ({1'b0, cursor_col} >= cols_eff) ? '0 : cursor_col;
      wt      <= ({1'b0, window_top} >= lines_eff) ? '0 : window_top;
    end
    if (cmd.calc) begin
      prod      <= {{(LIN_W-ROW_W){1'b0}}, cur_row} * {{(LIN_W-COLS_W){1'b0}}, cols_eff};
      new_row   <= tgt_row;
      new_col   <= tgt_col;
      prev_row  <= prv_row_c;
      prev_col  <= prv_col_c;
      scroll    <= scroll_c;
      new_top   <= scroll_c ? top_inc : wt;
      first_val <= (is_bs || is_nl) ? '0
                 : (tcw_pkg::CELL_CHAR | {{(CELL_W-tcw_pkg::CHAR_W){1'b0}}, code_r});
    end
    if (cmd.pick) begin
      if (ram_rdata == '0) begin
        new_row <= cur_row;
        new_col <= cur_col;
      end else begin
        new_row <= prev_row;
        new_col <= prev_col;
      end
    end
    if (cmd.mul) begin
      prod <= {{(LIN_W-ROW_W){1'b0}}, new_row} * {{(LIN_W-COLS_W){1'b0}}, cols_eff};
    end
    if (cmd.write_first) begin
      write_address <= addr_cur;
      cell_value    <= first_val;
      clear_line    <= 1'b0;
      top_line      <= new_top;
      last          <= 1'b0;
    end else if (cmd.emit_clear) begin
      write_address <= addr_line;
      cell_value    <= '0;
      clear_line    <= 1'b1;
      top_line      <= new_top;
      last          <= 1'b0;
    end else if (cmd.write_cursor) begin
      write_address <= addr_new;
      cell_value    <= tcw_pkg::CELL_CURSOR;
      clear_line    <= 1'b0;
      top_line      <= new_top;
      last          <= 1'b1;
    end
  end

  assign sts.is_bs      = is_bs;
  assign sts.scroll     = scroll;
  assign sts.out_free   = !out_valid || !out_stall;
  assign sts.sweep_done = cnt[COL_W-1:0] == cols_m1[COL_W-1:0];
  assign sts.init_done  = &cnt;

`ifndef SYNTHESIS
  a_clear_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clear_line) |-> (cell_value == '0 && !last))
    else $error("line clear with nonzero value or last flag");

  a_cursor_update: assert property (@(posedge clk) disable iff (rst)
    cmd.write_cursor |=> (cursor_row == $past(new_row) && cursor_col == $past(new_col)))
    else $error("cursor state not updated on final transaction");

  a_sweep_range: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep |-> ({1'b0, cnt[COL_W-1:0]} < cols_eff))
    else $error("line sweep ran past the line end");
`endif

endmodule

// ----- src/tcw_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: memory clearing pass, input handshake and the order of the cell
// writes, line clear and sweep for each character.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  tcw_pkg::status_t sts,
  output tcw_pkg::cmd_t    cmd
);

  tcw_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      tcw_pkg::S_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_done) begin
          state_next = tcw_pkg::S_IDLE;
        end
      end
      tcw_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = tcw_pkg::S_CALC;
        end
      end
      tcw_pkg::S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = tcw_pkg::S_FIRST;
      end
      tcw_pkg::S_FIRST: begin
        if (sts.out_free) begin
          cmd.write_first = 1'b1;
          state_next      = sts.is_bs ? tcw_pkg::S_READ : tcw_pkg::S_MUL;
        end
      end
      tcw_pkg::S_READ: begin
        cmd.read_prev = 1'b1;
        state_next    = tcw_pkg::S_PICK;
      end
      tcw_pkg::S_PICK: begin
        cmd.pick   = 1'b1;
        state_next = tcw_pkg::S_MUL;
      end
      tcw_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = sts.scroll ? tcw_pkg::S_CLEAR : tcw_pkg::S_CUR;
      end
      tcw_pkg::S_CLEAR: begin
        if (sts.out_free) begin
          cmd.emit_clear = 1'b1;
          state_next     = tcw_pkg::S_SWEEP;
        end
      end
      tcw_pkg::S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          state_next = tcw_pkg::S_CUR;
        end
      end
      tcw_pkg::S_CUR: begin
        if (sts.out_free) begin
          cmd.write_cursor = 1'b1;
          state_next       = tcw_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tcw_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_calc: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == tcw_pkg::S_CALC))
    else $error("accepted transaction not followed by calc");

  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_clear |=> (state == tcw_pkg::S_SWEEP))
    else $error("line clear not followed by sweep");

  a_cursor_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.write_cursor |=> (state == tcw_pkg::S_IDLE && !in_stall))
    else $error("final transaction did not return to idle");
`endif

endmodule

// ----- src/text_console_cell_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Character-to-cell writer for a text console held as a ring of lines.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 8192-cell mirror RAM to zero, one cell per
// cycle, and holds in_stall high until the sweep ends; APB writes are taken
// throughout. Each character then runs through the sequencer one at a time:
// load, calc and the first cell write; for a backspace, a RAM read of the
// earlier cell and a pick on its registered return; the multiply; a line
// clear and a sweep when the window scrolls, since the mirror RAM clears
// the new line one cell per cycle through its single write port; and last
// the cursor write. Results leave through an output register, so the next
// character is taken while the last result is still waiting; a stalled
// output holds the sequencer at its next result.
module text_console_cell_writer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcw_pkg::PADDR_W-1:0] paddr,
  input  logic [tcw_pkg::PDATA_W-1:0] pwdata,
  output logic [tcw_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tcw_pkg::ADDR_W-1:0]  write_address,
  output logic [tcw_pkg::CELL_W-1:0]  cell_value,
  output logic                        clear_line,
  output logic [tcw_pkg::ROW_W-1:0]   top_line,
  output logic                        last
);

  tcw_pkg::cfg_t    cfg;
  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t sts;

  tcw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcw_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .char_code     (char_code),
    .cmd           (cmd),
    .sts           (sts),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .write_address (write_address),
    .cell_value    (cell_value),
    .clear_line    (clear_line),
    .top_line      (top_line),
    .last          (last)
  );

endmodule

// ----- tb/sv/text_console_cell_writer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_writer_checker
// Passive watcher of the cell writer. It snoops APB register writes to keep
// its own copy of the geometry. For every accepted character it works out the
// cell writes and line clears that the block must produce, queues them, and
// compares each accepted output transaction with the oldest one queued.
// ----------------------------------------------------------------------------
module text_console_cell_writer_checker
  import tcw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [CHAR_W-1:0]  char_code,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [ADDR_W-1:0]  write_address,
  input  logic [CELL_W-1:0]  cell_value,
  input  logic               clear_line,
  input  logic [ROW_W-1:0]   top_line,
  input  logic               last,
  output int                 pending,
  output int                 fail_count
);

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [CELL_W-1:0] value;
    logic              clear;
    logic [ROW_W-1:0]  top;
    logic              last;
  } cell_write_t;

  cfg_t              geom;
  logic [CELL_W-1:0] cell_mirror [CELL_DEPTH];
  int unsigned       cur_row;
  int unsigned       cur_col;
  int unsigned       win_top;
  cell_write_t       step_writes [3];
  int                n_step;
  cell_write_t       writes_due [$];
  cell_write_t       want;
  int                errs;

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  task automatic write_cell(input int unsigned cols, input int unsigned row,
                            input int unsigned col, input logic [CELL_W-1:0] v);
    cell_mirror[row * MAX_COLUMNS + col] = v;
    step_writes[n_step].address = ADDR_W'(geom.base_address + 2 * (row * cols + col));
    step_writes[n_step].value   = v;
    step_writes[n_step].clear   = 1'b0;
    n_step++;
  endtask

  task automatic clear_row(input int unsigned cols, input int unsigned row);
    for (int unsigned i = 0; i < cols; i++) cell_mirror[row * MAX_COLUMNS + i] = '0;
    step_writes[n_step].address = ADDR_W'(geom.base_address + 2 * row * cols);
    step_writes[n_step].value   = '0;
    step_writes[n_step].clear   = 1'b1;
    n_step++;
  endtask

  // distance from the window top; the top line itself counts as a full ring
  function automatic int unsigned line_gap(input int unsigned line,
                                           input int unsigned lines);
    return (line > win_top) ? line - win_top : lines + line - win_top;
  endfunction

  task automatic predict_char(input logic [CHAR_W-1:0] code);
    int unsigned cols;
    int unsigned lines;
    int unsigned rows;
    int unsigned total;
    int unsigned idx;
    int unsigned old_row;
    cols = geom.columns;
    if (cols < 1) cols = 1;
    if (cols > MAX_COLUMNS) cols = MAX_COLUMNS;
    lines = geom.ring_lines;
    if (lines < 1) lines = 1;
    if (lines > MAX_LINES) lines = MAX_LINES;
    rows = geom.visible_rows;
    if (rows < 1) rows = 1;
    if (rows > lines) rows = lines;
    total  = cols * lines;
    n_step = 0;
    if (cur_row >= lines) cur_row = 0;
    if (cur_col >= cols) cur_col = 0;
    if (win_top >= lines) win_top = 0;

    if (code == CODE_BS) begin
      write_cell(cols, cur_row, cur_col, '0);
      idx = (cur_row * cols + cur_col + total - 1) % total;
      if (cell_mirror[(idx / cols) * MAX_COLUMNS + idx % cols] == '0) begin
        idx = (idx + 1) % total;
      end
      cur_row = idx / cols;
      cur_col = idx % cols;
      write_cell(cols, cur_row, cur_col, CELL_CURSOR);
    end else if (code == CODE_LF || code == CODE_CR) begin
      write_cell(cols, cur_row, cur_col, '0);
      cur_row = (cur_row + 1) % lines;
      cur_col = 0;
      if (line_gap(cur_row, lines) == rows) begin
        win_top = (win_top + 1) % lines;
        clear_row(cols, cur_row);
      end
      write_cell(cols, cur_row, cur_col, CELL_CURSOR);
    end else begin
      old_row = cur_row;
      write_cell(cols, cur_row, cur_col, CELL_CHAR | {8'h00, code});
      idx = (cur_row * cols + cur_col + 1) % total;
      cur_row = idx / cols;
      cur_col = idx % cols;
      if (cur_row != old_row && line_gap(cur_row, lines) == rows) begin
        win_top = (win_top + 1) % lines;
        clear_row(cols, cur_row);
      end
      write_cell(cols, cur_row, cur_col, CELL_CURSOR);
    end

    for (int i = 0; i < n_step; i++) begin
      step_writes[i].top  = ROW_W'(win_top);
      step_writes[i].last = (i == n_step - 1);
      writes_due.push_back(step_writes[i]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CELL_DEPTH; i++) cell_mirror[i] = '0;
      geom.columns      = RST_COLUMNS;
      geom.visible_rows = RST_VISIBLE_ROWS;
      geom.ring_lines   = RST_RING_LINES;
      geom.base_address = '0;
      cur_row = 0;
      cur_col = 0;
      win_top = 0;
      writes_due.delete();
      errs = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[PADDR_W-1:2]))
          REG_COLUMNS:      geom.columns      = pwdata[COLS_W-1:0];
          REG_VISIBLE_ROWS: geom.visible_rows = pwdata[LINES_W-1:0];
          REG_RING_LINES:   geom.ring_lines   = pwdata[LINES_W-1:0];
          REG_BASE_ADDRESS: geom.base_address = pwdata[ADDR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_char(char_code);
      if (out_valid && !out_stall) begin
        if (writes_due.size() == 0) begin
          errs++;
          if (errs <= 10) begin
            $display("unexpected transaction: addr %h value %h clear %b top %0d last %b",
                     write_address, cell_value, clear_line, top_line, last);
          end
        end else begin
          want = writes_due.pop_front();
          if (write_address !== want.address || cell_value !== want.value ||
              clear_line !== want.clear || top_line !== want.top || last !== want.last) begin
            errs++;
            if (errs <= 10) begin
              $display("mismatch: exp addr %h value %h clear %b top %0d last %b",
                       want.address, want.value, want.clear, want.top, want.last);
              $display("          got addr %h value %h clear %b top %0d last %b",
                       write_address, cell_value, clear_line, top_line, last);
            end
          end
        end
      end
    end
    pending    <= writes_due.size();
    fail_count <= errs;
  end

endmodule

// ----- tb/sv/text_console_cell_writer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_writer_tb
// Drives characters into the console cell writer over a series of ring
// geometries (minimum, zero, oversized, window deeper than ring, defaults),
// programmed over APB while the block is idle. A short directed run covers
// backspace at the first cell and scrolling with a window as deep as the
// ring; the rest is random text with newlines and backspaces. Both sides
// idle at random, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module text_console_cell_writer_tb;
  import tcw_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CHAR_W-1:0]  char_code = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ADDR_W-1:0]  write_address;
  logic [CELL_W-1:0]  cell_value;
  logic               clear_line;
  logic [ROW_W-1:0]   top_line;
  logic               last;

  int pending;
  int fail_count;
  int chars_sent = 0;
  int writes_taken = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  logic [CHAR_W-1:0] opening_text [21] = '{
    CODE_BS, 8'h00, 8'hFF, CODE_BS, CODE_LF, CODE_CR, CODE_LF,
    8'h20, 8'h41, 8'h7F, 8'h80, 8'hFE, 8'h01, 8'h07, 8'h09, 8'h0B, 8'h0C, 8'h0E, 8'h5A,
    CODE_BS, CODE_BS
  };

  always #5 clk = ~clk;

  text_console_cell_writer dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .char_code,
    .out_valid, .out_stall, .write_address, .cell_value, .clear_line, .top_line, .last
  );

  text_console_cell_writer_checker checker_i (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid, .in_stall, .char_code,
    .out_valid, .out_stall, .write_address, .cell_value, .clear_line, .top_line, .last,
    .pending, .fail_count
  );

  // output side: random stalls, one long hold-off, one calm stretch
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) writes_taken++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && writes_taken >= 150) begin
        hold_done = 1'b1;
        hold_left = 300;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !(writes_taken >= 300 && writes_taken < 420) &&
                     ($urandom_range(99) < 13);
      end
    end
  end

  task automatic apb_write(input reg_idx_t r, input logic [PDATA_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [PDATA_W-1:0] cols, input logic [PDATA_W-1:0] vis,
                              input logic [PDATA_W-1:0] ring, input logic [PDATA_W-1:0] base);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    apb_write(REG_COLUMNS, cols);
    apb_write(REG_VISIBLE_ROWS, vis);
    apb_write(REG_RING_LINES, ring);
    apb_write(REG_BASE_ADDRESS, base);
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] code);
    if (!(chars_sent >= 150 && chars_sent < 200)) begin
      while ($urandom_range(99) < 13) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    char_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic type_text(input int n, input int nl_pct, input int bs_pct);
    int r;
    logic [CHAR_W-1:0] code;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < nl_pct) code = $urandom_range(1) ? CODE_LF : CODE_CR;
      else if (r < nl_pct + bs_pct) code = CODE_BS;
      else code = CHAR_W'($urandom_range(255));
      send_char(code);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    set_geometry(4, 3, 3, 20'hFFFF8);
    foreach (opening_text[i]) send_char(opening_text[i]);

    set_geometry(6, 3, 5, $urandom_range(20'hFFFFF));
    type_text(80, 12, 12);
    set_geometry(1, 1, 1, 0);
    type_text(15, 20, 20);
    set_geometry(0, 0, 0, 20'hFFFFF);
    type_text(15, 20, 20);
    set_geometry(255, 127, 127, $urandom_range(20'hFFFFF));
    type_text(40, 35, 10);
    set_geometry(128, 2, 64, $urandom_range(20'hFFFFF));
    type_text(30, 30, 10);
    set_geometry(3, 10, 4, $urandom_range(20'hFFFFF));
    type_text(40, 15, 20);
    set_geometry(RST_COLUMNS, RST_VISIBLE_ROWS, RST_RING_LINES, 0);
    type_text(40, 25, 10);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("text_console_cell_writer_tb: clean");
    end else begin
      $display("text_console_cell_writer_tb: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("text_console_cell_writer_tb: errors");
    $finish;
  end

endmodule
